/* hdl/assert_macros.svh */
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define VTA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define VTA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hdl/vta_pkg.sv */
package vta_pkg;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* hdl/vta_ram.sv */
module vta_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/vta_div.sv */
module vta_div
  import vta_pkg::*;
#(
  parameter int NW = 73,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic [NW-1:0] quotient,
  output div_stat_t     stat
);

  localparam int CNTW = $clog2(NW + 1);

  logic [NW-1:0]   quo_r;
  logic [DW-1:0]   rem_r;
  logic [DW-1:0]   den_r;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r;
  logic            done_r;
  logic [DW:0]     rem_sh;
  logic [DW:0]     rem_sub;
  logic            ge;

  assign rem_sh  = {rem_r, quo_r[NW-1]};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign rem_sub = ge ? (rem_sh - {1'b0, den_r}) : rem_sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      den_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= {quo_r[NW-2:0], ge};
      rem_r <= rem_sub[DW-1:0];
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

/* hdl/vector_time_autocorrelation_top.sv */
// Vector time autocorrelation over a batch of frames.
// Input channel (in_valid/in_stall): one sample request per cycle while the
// block is idle, each written into the vector store at (frame, chain).
// The request with in_load_done set starts the evaluation; in_stall then
// stays high until every lag has been delivered and the store is cleared.
// Each pair of vectors is multiplied one dimension at a time on the single
// shared multiplier, and each lag below N-1 then takes one pass of the
// shared bit-serial divider to form its mean. Results then leave one per lag,
// lags 0 to N-1, with one divider pass per lag in mode 1, except for the
// last lag and for a zero lag-0 value.
// Output channel (out_valid/out_stall): a result request holds its payload
// while out_stall is high; the sequencer waits on it.
// After reset, and after the last lag of every batch, a clearing pass zeroes
// all MAX_FRAMES*MAX_CHAINS entries of the store with in_stall high.
// Configuration (APB, pready always high) must be written only while idle; the block itself does not enforce it.
module vector_time_autocorrelation_top
  import vta_pkg::*;
#(
  parameter int MAX_FRAMES = 64,
  parameter int MAX_CHAINS = 16,
  parameter int MAX_DIMS   = 3,
  parameter int FRAC_BITS  = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_comp_x,
  input  logic signed [15:0] in_comp_y,
  input  logic signed [15:0] in_comp_z,
  input  logic [3:0]         in_chain_idx,
  input  logic [5:0]         in_frame_idx,
  input  logic               in_load_done,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [5:0]         out_lag,
  output logic signed [31:0] out_acf_value,
  output logic               out_div_zero,
  output logic               out_last_result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  `include "assert_macros.svh"

  localparam int FW  = $clog2(MAX_FRAMES);
  localparam int NFW = $clog2(MAX_FRAMES + 1);
  localparam int NCW = $clog2(MAX_CHAINS + 1);
  localparam int SD  = MAX_FRAMES * MAX_CHAINS;
  localparam int AW  = $clog2(SD);
  localparam int TW  = NFW + NCW;
  localparam int UP  = (2 * FRAC_BITS < 16) ? 16 - 2 * FRAC_BITS : 0;
  localparam int DN  = (2 * FRAC_BITS > 16) ? 2 * FRAC_BITS - 16 : 0;
  localparam int NW  = 65 + UP;
  localparam int DW  = (TW + DN > 32) ? TW + DN : 32;

  localparam logic [1:0] REG_NUM_DIMS   = 2'd0;
  localparam logic [1:0] REG_NUM_CHAINS = 2'd1;
  localparam logic [1:0] REG_NUM_FRAMES = 2'd2;
  localparam logic [1:0] REG_NORM_MODE  = 2'd3;

  typedef enum logic [11:0] {
    S_CLEAR      = 12'b000000000001,
    S_IDLE       = 12'b000000000010,
    S_LAG_START  = 12'b000000000100,
    S_RD         = 12'b000000001000,
    S_MUL        = 12'b000000010000,
    S_ACC        = 12'b000000100000,
    S_MEAN_SETUP = 12'b000001000000,
    S_MEAN_WAIT  = 12'b000010000000,
    S_OUT_RD     = 12'b000100000000,
    S_OUT_CALC   = 12'b001000000000,
    S_OUT_DIV    = 12'b010000000000,
    S_OUT_HOLD   = 12'b100000000000
  } state_t;

  state_t             state_r;
  logic [1:0]         num_dims_r;
  logic [4:0]         num_chains_r;
  logic [6:0]         num_frames_r;
  logic               norm_mode_r;
  logic [AW-1:0]      clr_r;
  logic [NFW-1:0]     i_r;
  logic [NFW-1:0]     j_r;
  logic [NCW-1:0]     k_r;
  logic [1:0]         d_r;
  logic [TW-1:0]      terms_r;
  logic signed [63:0] acc_r;
  logic signed [31:0] prod_r;
  logic signed [31:0] lz_r;
  logic               dz_r;
  logic               div_neg_r;
  logic [5:0]         out_lag_r;
  logic signed [31:0] out_acf_r;
  logic               out_dz_r;
  logic               out_last_r;

  logic [1:0]         nd;
  logic [NCW-1:0]     nc;
  logic [NFW-1:0]     nf;
  logic               accept_in;
  logic               wr_in_ok;
  logic               st_we;
  logic [AW-1:0]      st_waddr;
  logic [47:0]        st_wdata;
  logic [AW-1:0]      pa;
  logic [AW-1:0]      qa;
  logic [47:0]        p_dat;
  logic [47:0]        q_dat;
  logic signed [15:0] pc;
  logic signed [15:0] qc;
  logic [31:0]        means_raw;
  logic signed [31:0] means_rd;
  logic [63:0]        mag64;
  logic [DW-1:0]      terms_sh;
  logic [NW-1:0]      mean_dvd;
  logic signed [32:0] num33;
  logic               rneg;
  logic [32:0]        rmag;
  logic [31:0]        lz_mag;
  logic [NW-1:0]      ratio_dvd;
  logic               ratio_go;
  logic               div_start;
  logic [NW-1:0]      div_dvd;
  logic [DW-1:0]      div_dsr;
  logic [NW-1:0]      div_q;
  div_stat_t          div_stat;
  logic signed [31:0] res_val;
  logic               not_last;
  logic               mean_we;
  logic               cfg_we;

  function automatic logic signed [31:0] to_q16(input logic [NW-1:0] q, input logic neg);
    logic [32:0] qs;
    logic [32:0] qn;
    qs = (q > NW'(64'h8000_0000)) ? 33'h0_8000_0000 : q[32:0];
    qn = -qs;
    if (neg) begin
      to_q16 = qn[31:0];
    end else begin
      to_q16 = (qs > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : qs[31:0];
    end
  endfunction

  // Register clamping.
  always_comb begin
    if (num_dims_r == 2'd0) begin
      nd = 2'd1;
    end else if (32'(num_dims_r) > MAX_DIMS) begin
      nd = 2'(MAX_DIMS);
    end else begin
      nd = num_dims_r;
    end
    if (num_chains_r == 5'd0) begin
      nc = NCW'(1);
    end else if (32'(num_chains_r) > MAX_CHAINS) begin
      nc = NCW'(MAX_CHAINS);
    end else begin
      nc = NCW'(num_chains_r);
    end
    if (num_frames_r < 7'd2) begin
      nf = NFW'(2);
    end else if (32'(num_frames_r) > MAX_FRAMES) begin
      nf = NFW'(MAX_FRAMES);
    end else begin
      nf = NFW'(num_frames_r);
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign accept_in = in_valid && !in_stall;
  assign wr_in_ok  = (32'(in_chain_idx) < MAX_CHAINS) && (32'(in_frame_idx) < MAX_FRAMES);
  assign st_we     = (accept_in && wr_in_ok) || (state_r == S_CLEAR);
  assign st_waddr  = (state_r == S_CLEAR) ? clr_r
                   : AW'(32'(in_frame_idx) * MAX_CHAINS + 32'(in_chain_idx));
  assign st_wdata  = (state_r == S_CLEAR) ? 48'd0 : {in_comp_z, in_comp_y, in_comp_x};
  assign pa        = AW'(32'(j_r) * MAX_CHAINS + 32'(k_r));
  assign qa        = AW'((32'(j_r) + 32'(i_r)) * MAX_CHAINS + 32'(k_r));

  // Two copies of the store so both vectors of a pair are read in the same cycle.
  vta_ram #(.WIDTH(48), .DEPTH(SD)) u_store_p (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata), .raddr(pa), .rdata(p_dat)
  );

  vta_ram #(.WIDTH(48), .DEPTH(SD)) u_store_q (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata), .raddr(qa), .rdata(q_dat)
  );

  assign mean_we = (state_r == S_MEAN_WAIT) && div_stat.done;

  vta_ram #(.WIDTH(32), .DEPTH(MAX_FRAMES)) u_means (
    .clk(clk), .we(mean_we), .waddr(i_r[FW-1:0]), .wdata(res_val),
    .raddr(i_r[FW-1:0]), .rdata(means_raw)
  );

  assign means_rd = $signed(means_raw);

  always_comb begin
    unique case (d_r)
      2'd0:    begin pc = $signed(p_dat[15:0]);  qc = $signed(q_dat[15:0]);  end
      2'd1:    begin pc = $signed(p_dat[31:16]); qc = $signed(q_dat[31:16]); end
      default: begin pc = $signed(p_dat[47:32]); qc = $signed(q_dat[47:32]); end
    endcase
  end

  // Operands of the shared divider.
  assign mag64     = acc_r[63] ? 64'(-acc_r) : 64'(acc_r);
  assign terms_sh  = DW'(terms_r) << DN;
  assign mean_dvd  = (NW'(mag64) << UP) + NW'(terms_sh >> 1);
  assign num33     = lz_r[31] ? -33'(means_rd) : 33'(means_rd);
  assign rneg      = num33[32];
  assign rmag      = rneg ? 33'(-num33) : 33'(num33);
  assign lz_mag    = lz_r[31] ? 32'(-33'(lz_r)) : 32'(lz_r);
  assign ratio_dvd = (NW'(rmag) << 16) + NW'(lz_mag >> 1);
  assign not_last  = (32'(i_r) + 32'd1) < 32'(nf);
  assign ratio_go  = norm_mode_r && !dz_r && not_last;
  assign div_start = (state_r == S_MEAN_SETUP) || ((state_r == S_OUT_CALC) && ratio_go);
  assign div_dvd   = (state_r == S_MEAN_SETUP) ? mean_dvd : ratio_dvd;
  assign div_dsr   = (state_r == S_MEAN_SETUP) ? terms_sh : DW'(lz_mag);

  vta_div #(.NW(NW), .DW(DW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dvd), .divisor(div_dsr),
    .quotient(div_q), .stat(div_stat)
  );

  assign res_val = to_q16(div_q, div_neg_r);

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[3:2])
      REG_NUM_DIMS:   prdata = {30'd0, num_dims_r};
      REG_NUM_CHAINS: prdata = {27'd0, num_chains_r};
      REG_NUM_FRAMES: prdata = {25'd0, num_frames_r};
      default:        prdata = {31'd0, norm_mode_r};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_dims_r   <= 2'd3;
      num_chains_r <= 5'd16;
      num_frames_r <= 7'd64;
      norm_mode_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        REG_NUM_DIMS:   num_dims_r   <= pwdata[1:0];
        REG_NUM_CHAINS: num_chains_r <= pwdata[4:0];
        REG_NUM_FRAMES: num_frames_r <= pwdata[6:0];
        default:        norm_mode_r  <= pwdata[0];
      endcase
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
      d_r     <= '0;
    end else begin
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == AW'(SD - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept_in && in_load_done) begin
            i_r     <= '0;
            state_r <= S_LAG_START;
          end
        end
        S_LAG_START: begin
          j_r     <= '0;
          k_r     <= '0;
          d_r     <= '0;
          state_r <= S_RD;
        end
        S_RD: begin
          state_r <= S_MUL;
        end
        S_MUL: begin
          state_r <= S_ACC;
        end
        S_ACC: begin
          if (d_r + 2'd1 < nd) begin
            d_r     <= d_r + 2'd1;
            state_r <= S_MUL;
          end else begin
            d_r <= '0;
            if (32'(k_r) + 32'd1 < 32'(nc)) begin
              k_r     <= k_r + 1'b1;
              state_r <= S_RD;
            end else begin
              k_r <= '0;
              if (32'(j_r) + 32'(i_r) + 32'd2 < 32'(nf)) begin
                j_r     <= j_r + 1'b1;
                state_r <= S_RD;
              end else begin
                state_r <= S_MEAN_SETUP;
              end
            end
          end
        end
        S_MEAN_SETUP: begin
          state_r <= S_MEAN_WAIT;
        end
        S_MEAN_WAIT: begin
          if (div_stat.done) begin
            if (32'(i_r) + 32'd2 < 32'(nf)) begin
              i_r     <= i_r + 1'b1;
              state_r <= S_LAG_START;
            end else begin
              i_r     <= '0;
              state_r <= S_OUT_RD;
            end
          end
        end
        S_OUT_RD: begin
          state_r <= S_OUT_CALC;
        end
        S_OUT_CALC: begin
          state_r <= ratio_go ? S_OUT_DIV : S_OUT_HOLD;
        end
        S_OUT_DIV: begin
          if (div_stat.done) begin
            state_r <= S_OUT_HOLD;
          end
        end
        S_OUT_HOLD: begin
          if (!out_stall) begin
            if (out_last_r) begin
              clr_r   <= '0;
              state_r <= S_CLEAR;
            end else begin
              i_r     <= i_r + 1'b1;
              state_r <= S_OUT_RD;
            end
          end
        end
        default: begin
          state_r <= S_CLEAR;
          clr_r   <= '0;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state_r == S_LAG_START) begin
      terms_r <= TW'((32'(nf) - 32'(i_r) - 32'd1) * 32'(nc));
      acc_r   <= '0;
    end
    if (state_r == S_MUL) begin
      prod_r <= pc * qc;
    end
    if (state_r == S_ACC) begin
      acc_r <= acc_r + 64'(prod_r);
    end
    if (state_r == S_MEAN_SETUP) begin
      div_neg_r <= acc_r[63];
    end else if ((state_r == S_OUT_CALC) && ratio_go) begin
      div_neg_r <= rneg;
    end
    if (mean_we) begin
      if (i_r == '0) begin
        lz_r <= res_val;
      end
      if (!(32'(i_r) + 32'd2 < 32'(nf))) begin
        dz_r <= norm_mode_r && (((i_r == '0) ? res_val : lz_r) == 32'sd0);
      end
    end
    if (state_r == S_OUT_CALC) begin
      out_lag_r  <= i_r[5:0];
      out_dz_r   <= dz_r;
      out_last_r <= !not_last;
      if (!not_last || dz_r) begin
        out_acf_r <= 32'sd0;
      end else if (!norm_mode_r) begin
        out_acf_r <= (i_r == '0) ? 32'sh0001_0000 : means_rd;
      end
    end
    if ((state_r == S_OUT_DIV) && div_stat.done) begin
      out_acf_r <= res_val;
    end
  end

  assign out_valid       = (state_r == S_OUT_HOLD);
  assign out_lag         = out_lag_r;
  assign out_acf_value   = out_acf_r;
  assign out_div_zero    = out_dz_r;
  assign out_last_result = out_last_r;

  `VTA_ASSERT_IMPL(a_out_blocks_in, out_valid, in_stall)
  `VTA_ASSERT_IMPL(a_div_start_idle, div_start, !div_stat.busy)
  `VTA_ASSERT_NEXT(a_last_clears, out_valid && out_last_result && !out_stall, state_r == S_CLEAR)
  `VTA_ASSERT_IMPL(a_ratio_mode1, state_r == S_OUT_DIV, norm_mode_r && !dz_r)

endmodule

/* tb/vta_acf_checker.sv */
module vta_acf_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [15:0] in_comp_x,
  input  logic signed [15:0] in_comp_y,
  input  logic signed [15:0] in_comp_z,
  input  logic [3:0]         in_chain_idx,
  input  logic [5:0]         in_frame_idx,
  input  logic               in_load_done,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [5:0]         out_lag,
  input  logic signed [31:0] out_acf_value,
  input  logic               out_div_zero,
  input  logic               out_last_result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output int                 error_count,
  output int                 lags_pending,
  output int                 lags_checked,
  output int                 batches_seen
);

  localparam int NUM_FRAMES_MAX = 64;
  localparam int NUM_CHAINS_MAX = 16;
  localparam int NUM_DIMS_MAX   = 3;
  localparam int FRAC           = 12;
  localparam int MEAN_SHIFT     = 2 * FRAC - 16;

  localparam logic [1:0] REG_NUM_DIMS   = 2'd0;
  localparam logic [1:0] REG_NUM_CHAINS = 2'd1;
  localparam logic [1:0] REG_NUM_FRAMES = 2'd2;
  localparam logic [1:0] REG_NORM_MODE  = 2'd3;

  typedef struct packed {
    logic [5:0]         lag;
    logic signed [31:0] acf;
    logic               div_zero;
    logic               last;
  } acf_result_t;

  acf_result_t acf_expected_q[$];
  logic signed [15:0] frame_store [0:NUM_FRAMES_MAX*NUM_CHAINS_MAX-1][0:2];
  logic [1:0] dims_reg;
  logic [4:0] chains_reg;
  logic [6:0] frames_reg;
  logic       mode_reg;

  function automatic logic signed [31:0] round_div(longint num, logic [63:0] den,
                                                   int up, int dn);
    logic        neg;
    logic [63:0] mag;
    logic [63:0] q;
    neg = num < 0;
    mag = neg ? 64'(-num) : 64'(num);
    mag = mag << up;
    den = den << dn;
    q = (mag + den / 2) / den;
    if (q > 64'h8000_0000) q = 64'h8000_0000;
    if (neg) return -q[31:0];
    if (q > 64'h7FFF_FFFF) return 32'h7FFF_FFFF;
    return q[31:0];
  endfunction

  task automatic evaluate_batch();
    int nd, nc, nf;
    longint acc;
    logic signed [31:0] means [0:NUM_FRAMES_MAX-1];
    logic signed [31:0] lag0, v;
    logic dz;
    acf_result_t r;
    nd = (dims_reg < 1) ? 1 : (dims_reg > NUM_DIMS_MAX ? NUM_DIMS_MAX : dims_reg);
    nc = (chains_reg < 1) ? 1 : (chains_reg > NUM_CHAINS_MAX ? NUM_CHAINS_MAX : chains_reg);
    nf = (frames_reg < 2) ? 2 : (frames_reg > NUM_FRAMES_MAX ? NUM_FRAMES_MAX : frames_reg);
    for (int i = 0; i + 1 < nf; i++) begin
      acc = 0;
      for (int j = 0; j + i + 1 < nf; j++)
        for (int k = 0; k < nc; k++)
          for (int d = 0; d < nd; d++)
            acc += longint'(frame_store[j*NUM_CHAINS_MAX+k][d]) *
                   longint'(frame_store[(j+i)*NUM_CHAINS_MAX+k][d]);
      means[i] = round_div(acc, 64'((nf - 1 - i) * nc), 0, MEAN_SHIFT);
    end
    lag0 = means[0];
    dz = mode_reg && (lag0 == 0);
    for (int i = 0; i < nf; i++) begin
      v = 0;
      if (i + 1 < nf && !dz) begin
        if (mode_reg) begin
          if (lag0 < 0) v = round_div(-longint'(means[i]), 64'(-longint'(lag0)), 16, 0);
          else v = round_div(longint'(means[i]), 64'(longint'(lag0)), 16, 0);
        end else begin
          v = (i == 0) ? 32'sd65536 : means[i];
        end
      end
      r.lag = i[5:0];
      r.acf = v;
      r.div_zero = dz;
      r.last = (i + 1 == nf);
      acf_expected_q.push_back(r);
    end
    for (int a = 0; a < NUM_FRAMES_MAX*NUM_CHAINS_MAX; a++)
      for (int d = 0; d < 3; d++) frame_store[a][d] = '0;
    batches_seen++;
  endtask

  assign lags_pending = acf_expected_q.size();

  always @(posedge clk) begin
    acf_result_t e;
    if (!rst_n) begin
      error_count = 0;
      lags_checked = 0;
      batches_seen = 0;
      dims_reg = 2'd3;
      chains_reg = 5'd16;
      frames_reg = 7'd64;
      mode_reg = 1'b0;
      for (int a = 0; a < NUM_FRAMES_MAX*NUM_CHAINS_MAX; a++)
        for (int d = 0; d < 3; d++) frame_store[a][d] = '0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_NUM_DIMS: begin
            dims_reg = pwdata[1:0];
          end
          REG_NUM_CHAINS: begin
            chains_reg = pwdata[4:0];
          end
          REG_NUM_FRAMES: begin
            frames_reg = pwdata[6:0];
          end
          REG_NORM_MODE: begin
            mode_reg = pwdata[0];
          end
          default: begin
          end
        endcase
      end
      if (in_valid && !in_stall) begin
        frame_store[in_frame_idx*NUM_CHAINS_MAX+in_chain_idx][0] = in_comp_x;
        frame_store[in_frame_idx*NUM_CHAINS_MAX+in_chain_idx][1] = in_comp_y;
        frame_store[in_frame_idx*NUM_CHAINS_MAX+in_chain_idx][2] = in_comp_z;
        if (in_load_done) evaluate_batch();
      end
      if (out_valid && !out_stall) begin
        lags_checked++;
        if (acf_expected_q.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result lag=%0d acf=%0d dz=%0b last=%0b", $time,
                   out_lag, out_acf_value, out_div_zero, out_last_result);
        end else begin
          e = acf_expected_q.pop_front();
          if (out_lag !== e.lag || out_acf_value !== e.acf ||
              out_div_zero !== e.div_zero || out_last_result !== e.last) begin
            error_count++;
            $display("%0t: mismatch expected lag=%0d acf=%0d dz=%0b last=%0b", $time,
                     e.lag, e.acf, e.div_zero, e.last);
            $display("%0t:          actual   lag=%0d acf=%0d dz=%0b last=%0b", $time,
                     out_lag, out_acf_value, out_div_zero, out_last_result);
          end
        end
      end
    end
  end

endmodule

/* tb/tb_vector_time_autocorrelation_top.sv */
module tb_vector_time_autocorrelation_top;

  localparam logic [3:0] ADDR_NUM_DIMS   = 4'd0;
  localparam logic [3:0] ADDR_NUM_CHAINS = 4'd4;
  localparam logic [3:0] ADDR_NUM_FRAMES = 4'd8;
  localparam logic [3:0] ADDR_NORM_MODE  = 4'd12;
  localparam int CLEAR_WAIT  = 1100;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int TARGET_REQUESTS = 410;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_comp_x = '0;
  logic signed [15:0] in_comp_y = '0;
  logic signed [15:0] in_comp_z = '0;
  logic [3:0] in_chain_idx = '0;
  logic [5:0] in_frame_idx = '0;
  logic in_load_done = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [5:0] out_lag;
  logic signed [31:0] out_acf_value;
  logic out_div_zero;
  logic out_last_result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  int error_count, lags_pending, lags_checked, batches_seen;
  int idle_pct = 0;
  int stall_pct = 0;
  int requests_sent = 0;
  int cycle_count = 0;
  int nf_eff, nc_eff;

  always #5 clk = ~clk;

  vector_time_autocorrelation_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_comp_x(in_comp_x), .in_comp_y(in_comp_y), .in_comp_z(in_comp_z),
    .in_chain_idx(in_chain_idx), .in_frame_idx(in_frame_idx),
    .in_load_done(in_load_done),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_lag(out_lag), .out_acf_value(out_acf_value),
    .out_div_zero(out_div_zero), .out_last_result(out_last_result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  vta_acf_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_comp_x(in_comp_x), .in_comp_y(in_comp_y), .in_comp_z(in_comp_z),
    .in_chain_idx(in_chain_idx), .in_frame_idx(in_frame_idx),
    .in_load_done(in_load_done),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_lag(out_lag), .out_acf_value(out_acf_value),
    .out_div_zero(out_div_zero), .out_last_result(out_last_result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .error_count(error_count), .lags_pending(lags_pending),
    .lags_checked(lags_checked), .batches_seen(batches_seen)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles.", cycle_count);
      $display("tb_vector_time_autocorrelation_top failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [3:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_sample(input logic [15:0] x, input logic [15:0] y,
                             input logic [15:0] z, input logic [3:0] ch,
                             input logic [5:0] fr, input logic ld);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_comp_x <= x;
    in_comp_y <= y;
    in_comp_z <= z;
    in_chain_idx <= ch;
    in_frame_idx <= fr;
    in_load_done <= ld;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    requests_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (lags_pending != 0) @(posedge clk);
    repeat (CLEAR_WAIT) @(posedge clk);
  endtask

  task automatic random_batch();
    int n;
    logic [31:0] v;
    if ($urandom_range(3) == 0) begin
      write_reg(ADDR_NUM_DIMS, $urandom_range(3));
    end
    v = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(1, 4);
    write_reg(ADDR_NUM_CHAINS, v);
    nc_eff = (v[4:0] < 1) ? 1 : (v[4:0] > 16 ? 16 : v[4:0]);
    if ($urandom_range(19) == 0 && nc_eff <= 2) v = $urandom_range(64, 127);
    else if ($urandom_range(9) == 0) v = $urandom_range(1);
    else v = $urandom_range(2, 8);
    write_reg(ADDR_NUM_FRAMES, v);
    nf_eff = (v[6:0] < 2) ? 2 : (v[6:0] > 64 ? 64 : v[6:0]);
    write_reg(ADDR_NORM_MODE, $urandom_range(1));
    n = $urandom_range(2, 14);
    for (int s = 0; s < n; s++) begin
      if ($urandom_range(7) == 0)
        send_sample(16'($urandom), 16'($urandom), 16'($urandom), 4'($urandom_range(15)),
                    6'($urandom_range(63)), s == n - 1);
      else
        send_sample(16'($urandom), 16'($urandom), 16'($urandom),
                    4'($urandom_range(nc_eff - 1)), 6'($urandom_range(nf_eff - 1)),
                    s == n - 1);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (CLEAR_WAIT) @(posedge clk);

    send_sample(16'sh8000, 16'sh7FFF, 16'sh0000, 4'd0, 6'd0, 1'b0);
    send_sample(16'sh7FFF, 16'sh8000, 16'shFFFF, 4'd15, 6'd63, 1'b0);
    send_sample(16'sh8000, 16'sh8000, 16'sh8000, 4'd15, 6'd0, 1'b0);
    send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 4'd0, 6'd1, 1'b1);
    wait_drained();

    write_reg(ADDR_NUM_DIMS, 32'd1);
    write_reg(ADDR_NUM_CHAINS, 32'd1);
    write_reg(ADDR_NUM_FRAMES, 32'd3);
    write_reg(ADDR_NORM_MODE, 32'd1);
    send_sample(16'sh0000, 16'sh1234, 16'sh4321, 4'd0, 6'd0, 1'b1);
    wait_drained();

    send_sample(16'sh1000, 16'sh0000, 16'sh0000, 4'd0, 6'd0, 1'b0);
    send_sample(16'shF000, 16'sh0000, 16'sh0000, 4'd0, 6'd1, 1'b0);
    send_sample(16'sh0800, 16'sh7FFF, 16'sh8000, 4'd0, 6'd2, 1'b1);
    wait_drained();

    write_reg(ADDR_NUM_DIMS, 32'd0);
    write_reg(ADDR_NUM_CHAINS, 32'd31);
    write_reg(ADDR_NUM_FRAMES, 32'd0);
    write_reg(ADDR_NORM_MODE, 32'd0);
    send_sample(16'sh0100, 16'sh0200, 16'sh0300, 4'd9, 6'd1, 1'b0);
    send_sample(16'sh7FFF, 16'sh0001, 16'sh0001, 4'd9, 6'd0, 1'b0);
    send_sample(16'sh0000, 16'sh0000, 16'sh0000, 4'd15, 6'd40, 1'b1);
    wait_drained();

    write_reg(ADDR_NUM_DIMS, 32'd3);
    write_reg(ADDR_NUM_CHAINS, 32'd2);
    write_reg(ADDR_NUM_FRAMES, 32'd127);
    write_reg(ADDR_NORM_MODE, 32'd1);
    send_sample(16'sh7FFF, 16'sh8000, 16'sh7FFF, 4'd1, 6'd63, 1'b0);
    send_sample(16'sh8000, 16'sh7FFF, 16'sh8000, 4'd0, 6'd0, 1'b1);
    wait_drained();

    for (int b = 0; requests_sent < TARGET_REQUESTS; b++) begin
      case ((b / 4) % 5)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 76;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 76;
        end
        3: begin
          idle_pct = 19;
          stall_pct = 19;
        end
        default: begin
          idle_pct = $urandom_range(50);
          stall_pct = $urandom_range(50);
        end
      endcase
      random_batch();
      wait_drained();
    end

    $display("Sent %0d sample requests in %0d batches; checked %0d lag results",
             requests_sent, batches_seen, lags_checked);
    $display("across all register settings, both normalization modes and idle mixes.");
    if (error_count == 0) begin
      $display("tb_vector_time_autocorrelation_top passed");
    end else begin
      $display("tb_vector_time_autocorrelation_top failed");
    end
    $finish;
  end

endmodule
